@@ rtl/dgpl_pkg.sv @@
// Shared types and constants of the DG positivity limiter.
package dgpl_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned ThrW  = 31;
  localparam logic [ThrW-1:0] DryThresholdReset = 31'd66;

  // One input transaction: node values plus the cell means
  typedef struct packed {
    logic signed [DataW-1:0] depth;
    logic signed [DataW-1:0] flow_x;
    logic signed [DataW-1:0] flow_y;
    logic signed [DataW-1:0] mean_depth;
    logic signed [DataW-1:0] mean_flow_x;
    logic signed [DataW-1:0] mean_flow_y;
    logic                    last_node;
  } in_item_t;

  // One result transaction
  typedef struct packed {
    logic signed [DataW-1:0] depth_out;
    logic signed [DataW-1:0] flow_x_out;
    logic signed [DataW-1:0] flow_y_out;
    logic                    last_out;
    logic                    overflow;
  } out_item_t;

  // Node record held in the cell store
  typedef struct packed {
    logic signed [DataW-1:0] depth;
    logic signed [DataW-1:0] flow_x;
    logic signed [DataW-1:0] flow_y;
  } node_t;

  // Controller commands to the datapath
  typedef struct packed {
    logic wr_en;      // store the accepted node
    logic first;      // node is the first of its cell
    logic ld_means;   // capture the cell means
    logic prep;       // classify theta and start the divider
    logic rd_en;      // read one stored node
    logic diff_en;    // form node minus mean
    logic mul_en;     // scale the differences by theta
    logic fin_en;     // round, recombine and present the result
    logic last_flag;  // result closes the cell
    logic ovf_flag;   // cell dropped nodes
  } cmd_t;

  // Datapath status to the controller
  typedef struct packed {
    logic div_done;
  } sts_t;

endpackage

@@ rtl/dg_positivity_limiter_unit.sv @@
// Top level of the DG positivity limiter: controller, datapath and checks.
//
// Each start transaction loads one node of a cell; for a node that is not
// the last one busy stays low. The transaction marked last_node raises busy:
// a prep state classifies theta and starts a restoring divider that forms
// theta one quotient bit per cycle and reports done, and then each kept node
// runs a read, difference, multiply and round sequence, so a cell holds busy
// through prep, the divide and that sequence for each kept node; the last
// result is on out_data in the cycle after busy falls. Every result appears
// on out_data for exactly one cycle with out_valid high; the receiver cannot
// stall it. Nodes beyond MAX_NODES are dropped and every result of that
// cell reports overflow.
// Write cfg_wdata only while idle.
module dg_positivity_limiter_unit import dgpl_pkg::*; #(
  parameter int unsigned MAX_NODES = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  in_item_t        in_data,
  output logic            out_valid,
  output out_item_t       out_data,
  input  logic            cfg_we,
  input  logic [ThrW-1:0] cfg_wdata
);

  localparam int unsigned AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned CW = $clog2(MAX_NODES + 1);

  cmd_t          cmd;
  sts_t          sts;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  dgpl_ctrl #(
    .MAX_NODES (MAX_NODES),
    .AW        (AW),
    .CW        (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .last_node (in_data.last_node),
    .busy      (busy),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .sts       (sts)
  );

  dgpl_dp #(
    .MAX_NODES (MAX_NODES),
    .AW        (AW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // A node that does not close its cell never raises busy
  a_mid_node_free: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_data.last_node |=> !busy)
    else $error("busy raised by a node that does not close the cell");

  // Closing a cell always starts the result sequence
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.last_node |=> busy)
    else $error("cell close did not raise busy");

  // A result is only produced out of a busy cycle
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a running cell");

  // The closing result of a cell is not followed by another at once
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_out |=> !out_valid)
    else $error("result right after the closing result");

endmodule

@@ rtl/dgpl_div.sv @@
// Restoring divider for theta: one quotient bit per cycle.
module dgpl_div import dgpl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DataW-1:0] num,
  input  logic [DataW:0]   den,
  output logic [DataW-1:0] quot,
  output logic             done
);

  logic [DataW:0]   rem_r, rem_nxt;
  logic [DataW:0]   den_r;
  logic [DataW-1:0] quot_r, quot_nxt;
  logic [4:0]       cnt_r;
  logic             run_r;
  logic             done_r;
  logic [DataW+1:0] shifted;
  logic [DataW+1:0] trial;

  // Shift in a zero bit and try a subtraction
  always_comb begin
    shifted  = {rem_r, 1'b0};
    trial    = shifted - {1'b0, den_r};
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    if (!trial[DataW+1]) begin
      rem_nxt  = trial[DataW:0];
      quot_nxt = {quot_r[DataW-2:0], 1'b1};
    end else begin
      rem_nxt  = shifted[DataW:0];
      quot_nxt = {quot_r[DataW-2:0], 1'b0};
    end
  end

  // Advance the iteration; the upper quotient half is known to be zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && run_r && (cnt_r == 5'd31);
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  // Hold the partial remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {1'b0, num};
      den_r  <= den;
      quot_r <= '0;
    end else if (run_r) begin
      rem_r  <= rem_nxt;
      quot_r <= quot_nxt;
    end
  end

  assign quot = quot_r;
  assign done = done_r;

endmodule

@@ rtl/dgpl_ctrl.sv @@
// Controller: node counting, cell sequencing and result timing.
module dgpl_ctrl import dgpl_pkg::*; #(
  parameter int unsigned MAX_NODES = 16,
  parameter int unsigned AW = 4,
  parameter int unsigned CW = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          last_node,
  output logic          busy,
  output cmd_t          cmd,
  output logic [AW-1:0] wr_addr,
  output logic [AW-1:0] rd_addr,
  input  sts_t          sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_DIFF = 3'd4;
  localparam logic [2:0] S_MUL  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          ovf_seen_r, ovf_seen_nxt;
  logic          ovf_cell_r, ovf_cell_nxt;
  logic          accept;
  logic          room;
  logic          last_res;

  assign accept   = start && (state_r == S_IDLE);
  assign room     = count_r < CW'(MAX_NODES);
  assign last_res = (idx_r + CW'(1)) == n_r;
  assign busy     = state_r != S_IDLE;
  assign wr_addr  = count_r[AW-1:0];
  assign rd_addr  = idx_r[AW-1:0];

  // Sequence the cell
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    n_nxt        = n_r;
    idx_nxt      = idx_r;
    ovf_seen_nxt = ovf_seen_r;
    ovf_cell_nxt = ovf_cell_r;
    cmd          = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.wr_en = room;
          cmd.first = count_r == '0;
          if (room) begin
            count_nxt = count_r + CW'(1);
          end else begin
            ovf_seen_nxt = 1'b1;
          end
          if (last_node) begin
            cmd.ld_means = 1'b1;
            n_nxt        = room ? count_r + CW'(1) : count_r;
            ovf_cell_nxt = ovf_seen_r || !room;
            count_nxt    = '0;
            ovf_seen_nxt = 1'b0;
            idx_nxt      = '0;
            state_nxt    = S_PREP;
          end
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff_en = 1'b1;
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        cmd.fin_en    = 1'b1;
        cmd.last_flag = last_res;
        cmd.ovf_flag  = ovf_cell_r;
        idx_nxt       = idx_r + CW'(1);
        state_nxt     = last_res ? S_IDLE : S_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      n_r        <= '0;
      idx_r      <= '0;
      ovf_seen_r <= 1'b0;
      ovf_cell_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      n_r        <= n_nxt;
      idx_r      <= idx_nxt;
      ovf_seen_r <= ovf_seen_nxt;
      ovf_cell_r <= ovf_cell_nxt;
    end
  end

endmodule

@@ rtl/dgpl_dp.sv @@
// Datapath: node store, minimum tracking, theta and per-node scaling.
module dgpl_dp import dgpl_pkg::*; #(
  parameter int unsigned MAX_NODES = 16,
  parameter int unsigned AW = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [ThrW-1:0] cfg_wdata,
  input  in_item_t        in_data,
  input  cmd_t            cmd,
  input  logic [AW-1:0]   wr_addr,
  input  logic [AW-1:0]   rd_addr,
  output sts_t            sts,
  output logic            out_valid,
  output out_item_t       out_data
);

  localparam logic [1:0] TM_ZERO = 2'd0;
  localparam logic [1:0] TM_ONE  = 2'd1;
  localparam logic [1:0] TM_DIV  = 2'd2;
  localparam int unsigned Lanes = 3;

  node_t                   store [MAX_NODES];
  node_t                   node_r;
  logic [ThrW-1:0]         thr_r;
  logic signed [DataW-1:0] min_r;
  logic signed [DataW-1:0] mean_r [Lanes];
  logic [1:0]              tmode_r;
  logic                    wet_r;
  logic                    neg_r  [Lanes];
  logic [DataW-1:0]        mag_r  [Lanes];
  logic [2*DataW-1:0]      prod_r [Lanes];
  logic                    neg2_r [Lanes];
  logic [DataW-1:0]        mag2_r [Lanes];
  logic                    out_valid_r;
  out_item_t               out_data_r;

  logic [DataW:0]          den;
  logic [DataW-1:0]        theta;
  logic                    div_done;
  logic signed [DataW-1:0] x_sel  [Lanes];
  logic [DataW:0]          diff   [Lanes];
  logic [2*DataW-1:0]      rnd    [Lanes];
  logic [DataW:0]          q      [Lanes];
  logic [DataW+1:0]        res    [Lanes];
  logic signed [DataW-1:0] lim    [Lanes];
  logic                    dry;
  logic                    wet_now;

  // Hold the dry threshold
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= DryThresholdReset;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  // Write and read the node store
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      store[wr_addr] <= '{depth: in_data.depth, flow_x: in_data.flow_x,
                          flow_y: in_data.flow_y};
    end
    if (cmd.rd_en) begin
      node_r <= store[rd_addr];
    end
  end

  // Track the minimum node depth of the cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= '0;
    end else if (cmd.wr_en && (cmd.first || (in_data.depth < min_r))) begin
      min_r <= in_data.depth;
    end
  end

  // Capture the cell means from the closing transaction
  always_ff @(posedge clk) begin
    if (cmd.ld_means) begin
      mean_r[0] <= in_data.mean_depth;
      mean_r[1] <= in_data.mean_flow_x;
      mean_r[2] <= in_data.mean_flow_y;
    end
  end

  // Classify theta: zero, one, or a quotient
  assign wet_now = mean_r[0] > 0;
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      wet_r <= wet_now;
      if (!wet_now || (min_r >= mean_r[0])) begin
        tmode_r <= TM_ZERO;
      end else if (min_r >= 0) begin
        tmode_r <= TM_ONE;
      end else begin
        tmode_r <= TM_DIV;
      end
    end
  end

  assign den = {mean_r[0][DataW-1], mean_r[0]} - {min_r[DataW-1], min_r};

  dgpl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.prep),
    .num   (mean_r[0]),
    .den   (den),
    .quot  (theta),
    .done  (div_done)
  );

  assign sts.div_done = div_done;

  // Difference from the mean, split into sign and magnitude
  always_comb begin
    x_sel[0] = node_r.depth;
    x_sel[1] = node_r.flow_x;
    x_sel[2] = node_r.flow_y;
    for (int i = 0; i < Lanes; i++) begin
      diff[i] = {x_sel[i][DataW-1], x_sel[i]} - {mean_r[i][DataW-1], mean_r[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.diff_en) begin
      for (int i = 0; i < Lanes; i++) begin
        neg_r[i] <= diff[i][DataW];
        mag_r[i] <= diff[i][DataW] ? DataW'(-diff[i]) : diff[i][DataW-1:0];
      end
    end
  end

  // Scale the magnitudes by theta
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      for (int i = 0; i < Lanes; i++) begin
        prod_r[i] <= mag_r[i] * theta;
        neg2_r[i] <= neg_r[i];
        mag2_r[i] <= mag_r[i];
      end
    end
  end

  // Round to nearest at the binary point and add back the mean
  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      rnd[i] = prod_r[i] + (2*DataW)'(64'h8000_0000);
      case (tmode_r)
        TM_ONE:  q[i] = {1'b0, mag2_r[i]};
        TM_DIV:  q[i] = {1'b0, rnd[i][2*DataW-1:DataW]};
        default: q[i] = '0;
      endcase
      if (neg2_r[i]) begin
        res[i] = {{2{mean_r[i][DataW-1]}}, mean_r[i]} - {1'b0, q[i]};
      end else begin
        res[i] = {{2{mean_r[i][DataW-1]}}, mean_r[i]} + {1'b0, q[i]};
      end
      lim[i] = wet_r ? res[i][DataW-1:0] : '0;
    end
    dry = $signed({lim[0][DataW-1], lim[0]}) < $signed({2'b00, thr_r});
  end

  // Register the result for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.fin_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_en) begin
      out_data_r.depth_out  <= lim[0];
      out_data_r.flow_x_out <= dry ? '0 : lim[1];
      out_data_r.flow_y_out <= dry ? '0 : lim[2];
      out_data_r.last_out   <= cmd.last_flag;
      out_data_r.overflow   <= cmd.ovf_flag;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the DG positivity limiter unit.
module tb;
  import dgpl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxNodes = 16;
  // Longest busy stretch of one cell plus some margin
  localparam int TailCycles = 40 + 4 * MaxNodes;
  localparam logic signed [DataW-1:0] WordMax = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] WordMin = 32'sh8000_0000;
  localparam longint SatHi = 64'sd2147483647;
  localparam longint SatLo = -64'sd2147483648;

  typedef enum int {KIND_WET, KIND_SHALLOW, KIND_DRY, KIND_NOISE} cell_kind_t;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            start;
  logic            busy;
  in_item_t        in_data;
  logic            out_valid;
  out_item_t       out_data;
  logic            cfg_we;
  logic [ThrW-1:0] cfg_wdata;

  // Limiter state as the block should hold it
  logic signed [DataW-1:0] cell_depth [MaxNodes];
  logic signed [DataW-1:0] cell_fx [MaxNodes];
  logic signed [DataW-1:0] cell_fy [MaxNodes];
  int                      cell_count = 0;
  logic signed [DataW-1:0] cell_min = '0;
  logic                    cell_dropped = 1'b0;
  logic [ThrW-1:0]         dry_thr = DryThresholdReset;

  out_item_t limited_q[$];
  int        errors = 0;
  int        sent_items = 0;
  bit        calm = 1'b0;
  bit        idle_on = 1'b1;

  dg_positivity_limiter_unit #(.MAX_NODES(MaxNodes)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Pull x toward mean by theta (Q1.32), rounding the magnitude half away from zero
  function automatic logic signed [DataW-1:0] scale_to_mean(
    input logic signed [DataW-1:0] x,
    input logic signed [DataW-1:0] mean,
    input logic [32:0]             theta
  );
    longint      d;
    longint      r;
    logic [63:0] mag;
    logic [65:0] prod;
    logic [33:0] q;
    d = longint'(x) - longint'(mean);
    mag = (d < 0) ? -d : d;
    prod = mag * theta + 66'h8000_0000;
    q = prod[65:32];
    r = (d < 0) ? longint'(mean) - longint'(q) : longint'(mean) + longint'(q);
    if (r > SatHi) r = SatHi;
    if (r < SatLo) r = SatLo;
    return r[DataW-1:0];
  endfunction

  // Accumulate one accepted node; on the cell's last node queue the limited nodes
  function automatic void predict_limited(input in_item_t item);
    out_item_t               res;
    logic [32:0]             theta;
    logic [63:0]             num;
    longint                  den;
    logic signed [DataW-1:0] hm, xm, ym, ho, xo, yo;
    if (cell_count < MaxNodes) begin
      cell_depth[cell_count] = item.depth;
      cell_fx[cell_count] = item.flow_x;
      cell_fy[cell_count] = item.flow_y;
      if (cell_count == 0 || item.depth < cell_min) cell_min = item.depth;
      cell_count++;
    end else begin
      cell_dropped = 1'b1;
    end
    if (!item.last_node) return;

    hm = item.mean_depth;
    xm = item.mean_flow_x;
    ym = item.mean_flow_y;
    theta = '0;
    if (hm > 0 && cell_min < hm) begin
      if (cell_min >= 0) begin
        theta = 33'h1_0000_0000;
      end else begin
        den = longint'(hm) - longint'(cell_min);
        num = {hm, 32'h0};
        theta = 33'(num / den);
      end
    end

    for (int i = 0; i < cell_count; i++) begin
      ho = '0;
      xo = '0;
      yo = '0;
      if (hm > 0) begin
        ho = scale_to_mean(cell_depth[i], hm, theta);
        xo = scale_to_mean(cell_fx[i], xm, theta);
        yo = scale_to_mean(cell_fy[i], ym, theta);
        // Dry node: drop the discharges
        if (longint'(ho) < longint'(dry_thr)) begin
          xo = '0;
          yo = '0;
        end
      end
      res.depth_out = ho;
      res.flow_x_out = xo;
      res.flow_y_out = yo;
      res.last_out = (i == cell_count - 1);
      res.overflow = cell_dropped;
      limited_q.push_back(res);
    end
    cell_count = 0;
    cell_min = '0;
    cell_dropped = 1'b0;
  endfunction

  function automatic void check_field(input string what, input logic [DataW-1:0] want_v,
                                      input logic [DataW-1:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want_v, got_v);
      errors++;
    end
  endfunction

  // Compare every result transaction against the oldest limited node
  always @(posedge clk) begin : check_results
    out_item_t want_item;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (limited_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        errors++;
      end else begin
        want_item = limited_q.pop_front();
        check_field("depth_out", want_item.depth_out, out_data.depth_out);
        check_field("flow_x_out", want_item.flow_x_out, out_data.flow_x_out);
        check_field("flow_y_out", want_item.flow_y_out, out_data.flow_y_out);
        check_field("last_out", 32'(want_item.last_out), 32'(out_data.last_out));
        check_field("overflow", 32'(want_item.overflow), 32'(out_data.overflow));
      end
    end
  end

  function automatic logic signed [DataW-1:0] rand_word();
    case ($urandom_range(0, 5))
      0: return WordMax;
      1: return WordMin;
      2: return '0;
      3: return int'($urandom_range(0, 2)) - 1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly modest discharges, now and then anything at all
  function automatic logic signed [DataW-1:0] flow_word();
    if ($urandom_range(0, 7) == 0) return rand_word();
    return int'($urandom_range(0, 1 << 21)) - (1 << 20);
  endfunction

  function automatic in_item_t mk_node(
    input logic signed [DataW-1:0] h, fx, fy, hm, xm, ym,
    input logic                    last
  );
    in_item_t item;
    item.depth = h;
    item.flow_x = fx;
    item.flow_y = fy;
    item.mean_depth = hm;
    item.mean_flow_x = xm;
    item.mean_flow_y = ym;
    item.last_node = last;
    return item;
  endfunction

  function automatic int pick_size();
    if ($urandom_range(0, 7) == 0) return $urandom_range(MaxNodes + 1, MaxNodes + 4);
    return $urandom_range(1, MaxNodes);
  endfunction

  function automatic cell_kind_t pick_kind();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 12) return KIND_WET;
    if (roll < 15) return KIND_SHALLOW;
    if (roll < 17) return KIND_DRY;
    return KIND_NOISE;
  endfunction

  // Present one node at the falling edge and hold it until the block takes it
  task automatic send_node(input in_item_t item);
    int gap;
    gap = 0;
    if (!calm && idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    in_data = item;
    do @(posedge clk); while (busy);
    predict_limited(item);
    sent_items++;
  endtask

  // Send one cell of n nodes; means on non-last nodes are junk the block ignores
  task automatic send_cell(input int n, input cell_kind_t kind);
    in_item_t item;
    int       span;
    span = $urandom_range(1, 1 << 20);
    idle_on = ($urandom_range(0, 2) != 0);
    for (int i = 0; i < n; i++) begin
      item.last_node = (i == n - 1);
      case (kind)
        KIND_WET:     item.depth = int'($urandom_range(0, 3 * span)) - span;
        KIND_SHALLOW: item.depth = $urandom_range(0, 2 * span);
        default:      item.depth = rand_word();
      endcase
      item.flow_x = (kind == KIND_NOISE) ? rand_word() : flow_word();
      item.flow_y = (kind == KIND_NOISE) ? rand_word() : flow_word();
      item.mean_flow_x = (kind == KIND_NOISE) ? rand_word() : flow_word();
      item.mean_flow_y = (kind == KIND_NOISE) ? rand_word() : flow_word();
      if (!item.last_node || kind == KIND_NOISE) begin
        item.mean_depth = rand_word();
      end else if (kind == KIND_DRY) begin
        case ($urandom_range(0, 2))
          0:       item.mean_depth = '0;
          1:       item.mean_depth = WordMin;
          default: item.mean_depth = -int'($urandom_range(1, 1 << 20));
        endcase
      end else begin
        item.mean_depth = span;
      end
      send_node(item);
    end
  endtask

  // Drop start and hold off until every limited node has come out
  task automatic settle_block();
    @(negedge clk);
    start = 1'b0;
    while (limited_q.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [ThrW-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    dry_thr = value;
  endtask

  // Field extremes, both theta limits, dry mean, dry node and a dropped last node
  task automatic test_directed_corners();
    send_node(mk_node(WordMax, WordMax, WordMin, WordMax, WordMin, WordMax, 1'b1));
    send_node(mk_node(WordMin, WordMax, WordMin, WordMin, WordMax, WordMin, 1'b0));
    send_node(mk_node('0, WordMin, WordMax, 32'sd1, WordMin, WordMax, 1'b1));
    send_node(mk_node(32'sh0005_0000, 32'sd1000, -32'sd1000, '0, 32'sd7, -32'sd7, 1'b1));
    send_node(mk_node(WordMax, WordMax, WordMax, WordMin, WordMax, WordMax, 1'b1));
    send_node(mk_node(32'sh0004_0000, 32'sh0003_0000, -32'sh0003_0000,
                      '0, '0, '0, 1'b0));
    send_node(mk_node(32'sd10, 32'sh0005_0000, 32'sh0005_0000,
                      32'sh0002_0000, 32'sh0001_0000, -32'sh0001_0000, 1'b1));
    send_cell(MaxNodes + 1, KIND_WET);
    settle_block();
  endtask

  // Sweep the dry threshold over its extremes and some random settings
  task automatic test_dry_threshold_sweep();
    logic [ThrW-1:0] sweep [5];
    int              goal;
    sweep[0] = '0;
    sweep[1] = {ThrW{1'b1}};
    sweep[2] = ThrW'($urandom_range(0, 1 << 20));
    sweep[3] = ThrW'($urandom);
    sweep[4] = DryThresholdReset;
    foreach (sweep[k]) begin
      write_threshold(sweep[k]);
      goal = sent_items + 10;
      while (sent_items < goal) send_cell(pick_size(), pick_kind());
      settle_block();
    end
  endtask

  task automatic test_random_cells();
    int goal;
    goal = sent_items + 30;
    while (sent_items < goal) send_cell(pick_size(), pick_kind());
    settle_block();
  endtask

  // Close with nodes offered on every cycle, each held while the block is busy
  task automatic test_back_to_back();
    int goal;
    calm = 1'b1;
    goal = sent_items + 20;
    while (sent_items < goal) send_cell(pick_size(), pick_kind());
    settle_block();
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_corners();
    test_dry_threshold_sweep();
    test_random_cells();
    test_back_to_back();

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ files.f @@
rtl/dgpl_pkg.sv
rtl/dgpl_div.sv
rtl/dgpl_ctrl.sv
rtl/dgpl_dp.sv
rtl/dg_positivity_limiter_unit.sv
tb/sv/tb.sv
